>>> rtl/brace_nesting_depth_guard_core_macros.svh
// Assertion macros shared by the brace nesting depth guard RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef BRACE_NESTING_DEPTH_GUARD_CORE_MACROS_SVH
`define BRACE_NESTING_DEPTH_GUARD_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BDG_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("brace depth guard: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BDG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("brace depth guard: next-cycle check failed");

`endif

>>> rtl/bdg_pkg.sv
// Shared types and constants for the brace nesting depth guard.
// No dependencies; imported by every module of the block.
package bdg_pkg;

  localparam int unsigned DEPTH_W = 17;
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned MODE_W  = 4;

  localparam logic [LIMIT_W-1:0] RESET_LIMIT = 16'd1024;

  // Lexer modes. Codes not listed here behave like code mode.
  localparam logic [MODE_W-1:0] M_CODE      = 4'd0;
  localparam logic [MODE_W-1:0] M_CODE_DASH = 4'd1;
  localparam logic [MODE_W-1:0] M_DASH2     = 4'd2;
  localparam logic [MODE_W-1:0] M_DASH2_BRK = 4'd3;
  localparam logic [MODE_W-1:0] M_LINE      = 4'd4;
  localparam logic [MODE_W-1:0] M_BLOCK     = 4'd5;
  localparam logic [MODE_W-1:0] M_BLOCK_BRK = 4'd6;
  localparam logic [MODE_W-1:0] M_SQ        = 4'd7;
  localparam logic [MODE_W-1:0] M_SQ_ESC    = 4'd8;
  localparam logic [MODE_W-1:0] M_DQ        = 4'd9;
  localparam logic [MODE_W-1:0] M_DQ_ESC    = 4'd10;

  // Characters the lexer reacts to.
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [DEPTH_W-1:0] depth;
    logic               flag;
  } bdg_state_t;

  typedef struct packed {
    logic limit_exceeded;
    logic source_done;
  } bdg_result_t;

  localparam bdg_state_t STATE_RESET = '{mode: M_CODE, depth: '0, flag: 1'b0};

endpackage

>>> rtl/bdg_lexer.sv
// Combinational per-byte scanner update: lexer mode, brace depth, sticky flag.
// Depends on bdg_pkg.
module bdg_lexer (
  input  bdg_pkg::bdg_state_t          cur,
  input  logic [7:0]                   byte_in,
  input  logic [bdg_pkg::LIMIT_W-1:0]  limit,
  output bdg_pkg::bdg_state_t          nxt
);
  import bdg_pkg::*;

  bdg_state_t        code_nxt;
  logic [DEPTH_W-1:0] depth_inc;

  assign depth_inc = cur.depth + {{(DEPTH_W-1){1'b0}}, 1'b1};

  // What a byte does when it is scanned as code.
  always_comb begin
    code_nxt      = cur;
    code_nxt.mode = M_CODE;
    if (byte_in == CH_DASH) begin
      code_nxt.mode = M_CODE_DASH;
    end else if (byte_in == CH_SQUOTE) begin
      code_nxt.mode = M_SQ;
    end else if (byte_in == CH_DQUOTE) begin
      code_nxt.mode = M_DQ;
    end else if (byte_in == CH_LBRACE) begin
      if (!cur.flag) begin
        code_nxt.depth = depth_inc;
        if (depth_inc > {1'b0, limit}) begin
          code_nxt.flag = 1'b1;
        end
      end
    end else if (byte_in == CH_RBRACE) begin
      if (!cur.flag && (cur.depth != '0)) begin
        code_nxt.depth = cur.depth - {{(DEPTH_W-1){1'b0}}, 1'b1};
      end
    end
  end

  always_comb begin
    nxt = cur;
    unique case (cur.mode) inside
      M_CODE_DASH: begin
        if (byte_in == CH_DASH) nxt.mode = M_DASH2;
        else                    nxt = code_nxt;
      end
      M_DASH2, M_DASH2_BRK: begin
        if (byte_in == CH_LBRACK) begin
          nxt.mode = (cur.mode == M_DASH2) ? M_DASH2_BRK : M_BLOCK;
        end else begin
          nxt.mode = (byte_in == CH_NL) ? M_CODE : M_LINE;
        end
      end
      M_LINE: begin
        nxt.mode = (byte_in == CH_NL) ? M_CODE : M_LINE;
      end
      M_BLOCK: begin
        nxt.mode = (byte_in == CH_RBRACK) ? M_BLOCK_BRK : M_BLOCK;
      end
      M_BLOCK_BRK: begin
        nxt.mode = (byte_in == CH_RBRACK) ? M_CODE : M_BLOCK;
      end
      M_SQ: begin
        if (byte_in == CH_BSLASH)      nxt.mode = M_SQ_ESC;
        else if (byte_in == CH_SQUOTE) nxt.mode = M_CODE;
      end
      M_SQ_ESC: nxt.mode = M_SQ;
      M_DQ: begin
        if (byte_in == CH_BSLASH)      nxt.mode = M_DQ_ESC;
        else if (byte_in == CH_DQUOTE) nxt.mode = M_CODE;
      end
      M_DQ_ESC: nxt.mode = M_DQ;
      default:  nxt = code_nxt;
    endcase
  end

endmodule

>>> rtl/bdg_out_buf.sv
// Two-entry result buffer (output register plus skid entry).
// Depends on bdg_pkg.
module bdg_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  bdg_pkg::bdg_result_t push_data,
  input  logic                 pop,
  output bdg_pkg::bdg_result_t head,
  output logic                 nonempty,
  output logic                 full
);
  import bdg_pkg::*;

  logic [1:0]  count;
  bdg_result_t r0;
  bdg_result_t r1;

  assign head     = r0;
  assign nonempty = (count != 2'd0);
  assign full     = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (!push && pop) begin
      count <= count - 2'd1;
    end
  end

  // The head takes new data when it is empty or drains in the same cycle;
  // otherwise a push lands in the skid entry.
  always_ff @(posedge clk) begin
    if (push && ((count == 2'd0) || ((count == 2'd1) && pop))) begin
      r0 <= push_data;
    end else if (pop && (count == 2'd2)) begin
      r0 <= r1;
    end
    if (push && (count == 2'd1) && !pop) begin
      r1 <= push_data;
    end
  end

endmodule

>>> rtl/brace_nesting_depth_guard_core.sv
// Top level of the brace nesting depth guard: input register, lexer, result buffer.
// Depends on bdg_pkg, bdg_lexer, bdg_out_buf and brace_nesting_depth_guard_core_macros.svh.
//
//   Channel | Handshake                    | Payload
//   --------+------------------------------+-------------------------------------
//   in      | in_valid / in_stall          | source_byte[7:0], end_of_source
//   out     | out_valid / out_stall        | limit_exceeded, source_done
//   cfg     | cfg_we (no wait)             | cfg_wdata[15:0] -> nesting limit
//
// A request waits in the input register, is scanned on the cycle it leaves
// it and has its result registered in the buffer that drives the output.
// The sustained rate is one byte per cycle while the result buffer has room,
// set by the single lexer update per cycle. rst is synchronous and active
// high; it returns the scanner to code mode with zero depth and loads the
// limit with 1024. When out_stall holds, up to two results wait in the buffer
// and one more request sits in the input register before in_stall rises.
module brace_nesting_depth_guard_core (
  input  logic        clk,
  input  logic        rst,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  source_byte,
  input  logic        end_of_source,
  // Output channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic        limit_exceeded,
  output logic        source_done,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import bdg_pkg::*;

  `include "brace_nesting_depth_guard_core_macros.svh"

  // Configuration register: the greatest allowed brace depth.
  logic [LIMIT_W-1:0] nesting_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      nesting_limit <= RESET_LIMIT;
    end else if (cfg_we) begin
      nesting_limit <= cfg_wdata;
    end
  end

  // Input register. It is refilled whenever it empties in the same cycle,
  // so a request can enter every cycle while the result buffer has room.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_eos;
  logic       in_take;
  logic       push;
  logic       buf_full;

  assign in_stall = s1_valid && buf_full;
  assign in_take  = in_valid && !in_stall;
  assign push     = s1_valid && !buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= source_byte;
      s1_eos  <= end_of_source;
    end
  end

  // Scanner state advances exactly when a byte leaves the input register.
  bdg_state_t state;
  bdg_state_t state_next;
  bdg_state_t lex_next;

  bdg_lexer u_lexer (
    .cur     (state),
    .byte_in (s1_byte),
    .limit   (nesting_limit),
    .nxt     (lex_next)
  );

  // The final byte of a source reports its verdict and then clears the scanner.
  always_comb begin
    state_next = state;
    if (push) begin
      state_next = s1_eos ? STATE_RESET : lex_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else begin
      state <= state_next;
    end
  end

  // Result buffer: the flag after this byte, and the end-of-source echo.
  bdg_result_t res_in;
  bdg_result_t res_head;
  logic        pop;

  assign res_in.limit_exceeded = lex_next.flag;
  assign res_in.source_done    = s1_eos;
  assign pop                   = out_valid && !out_stall;

  bdg_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res_in),
    .pop       (pop),
    .head      (res_head),
    .nonempty  (out_valid),
    .full      (buf_full)
  );

  assign limit_exceeded = res_head.limit_exceeded;
  assign source_done    = res_head.source_done;

  // The scanner is back in its reset state after the last byte of a source.
  `BDG_ASSERT_NEXT(a_eos_clears, clk, rst, push && s1_eos, state == STATE_RESET)
  // The flag stays set for the rest of the source.
  `BDG_ASSERT_NEXT(a_flag_sticky, clk, rst, push && !s1_eos && state.flag, state.flag)
  // Once flagged, the depth no longer moves.
  `BDG_ASSERT_NEXT(a_depth_frozen, clk, rst, push && !s1_eos && state.flag, $stable(state.depth))
  // The scanner only moves when a byte is handed to the result buffer.
  `BDG_ASSERT_NEXT(a_state_holds, clk, rst, !push, $stable(state))

endmodule

>>> verif/brace_nesting_depth_guard_core_tb.sv
// Testbench for brace_nesting_depth_guard_core: directed lexer cases and random script sources.
// Depends on bdg_pkg and the core RTL; results are checked against a predictor kept in this file.
`timescale 1ns / 100ps

module brace_nesting_depth_guard_core_tb;
  import bdg_pkg::*;

  // The run is cut off here; a correct run needs a small fraction of this.
  localparam int unsigned CYCLE_LIMIT = 400_000;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  source_byte = '0;
  logic        end_of_source = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        limit_exceeded;
  logic        source_done;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  // Idling controls, changed by the tests. stall_hold counts down a forced
  // stretch of output stall; the result monitor does the counting.
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_hold = 0;
  int unsigned mismatch_count = 0;

  // Predictor state: a private copy of the scanner and of the limit register.
  logic [MODE_W-1:0]  lex_mode = M_CODE;
  logic [DEPTH_W-1:0] brace_depth = '0;
  logic               over_limit = 1'b0;
  logic [LIMIT_W-1:0] depth_limit = RESET_LIMIT;

  // Verdicts expected for accepted requests, oldest first.
  bdg_result_t verdict_q[$];

  brace_nesting_depth_guard_core u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .source_byte   (source_byte),
    .end_of_source (end_of_source),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .limit_exceeded(limit_exceeded),
    .source_done   (source_done),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // A byte seen in code: quotes and dashes open new modes, braces move the
  // depth. Once the source is flagged the depth is frozen until the end.
  function automatic logic [MODE_W-1:0] code_char(input logic [7:0] b);
    if (b == CH_DASH) return M_CODE_DASH;
    if (b == CH_SQUOTE) return M_SQ;
    if (b == CH_DQUOTE) return M_DQ;
    if (!over_limit) begin
      if (b == CH_LBRACE) begin
        brace_depth = brace_depth + 1'b1;
        if (brace_depth > {1'b0, depth_limit}) over_limit = 1'b1;
      end else if (b == CH_RBRACE && brace_depth != '0) begin
        brace_depth = brace_depth - 1'b1;
      end
    end
    return M_CODE;
  endfunction

  // Advances the predicted scanner by one byte and returns the verdict the
  // block must give for it. The last byte of a source clears the scanner.
  function automatic bdg_result_t scan_byte(input logic [7:0] b, input logic last);
    bdg_result_t res;
    case (lex_mode)
      M_CODE_DASH: lex_mode = (b == CH_DASH) ? M_DASH2 : code_char(b);
      M_DASH2: begin
        if (b == CH_LBRACK) lex_mode = M_DASH2_BRK;
        else lex_mode = (b == CH_NL) ? M_CODE : M_LINE;
      end
      M_DASH2_BRK: begin
        if (b == CH_LBRACK) lex_mode = M_BLOCK;
        else lex_mode = (b == CH_NL) ? M_CODE : M_LINE;
      end
      M_LINE:      lex_mode = (b == CH_NL) ? M_CODE : M_LINE;
      M_BLOCK:     lex_mode = (b == CH_RBRACK) ? M_BLOCK_BRK : M_BLOCK;
      M_BLOCK_BRK: lex_mode = (b == CH_RBRACK) ? M_CODE : M_BLOCK;
      M_SQ: begin
        if (b == CH_BSLASH) lex_mode = M_SQ_ESC;
        else if (b == CH_SQUOTE) lex_mode = M_CODE;
      end
      M_SQ_ESC: lex_mode = M_SQ;
      M_DQ: begin
        if (b == CH_BSLASH) lex_mode = M_DQ_ESC;
        else if (b == CH_DQUOTE) lex_mode = M_CODE;
      end
      M_DQ_ESC: lex_mode = M_DQ;
      default:  lex_mode = code_char(b);
    endcase
    res.limit_exceeded = over_limit;
    res.source_done    = last;
    if (last) begin
      lex_mode    = M_CODE;
      brace_depth = '0;
      over_limit  = 1'b0;
    end
    return res;
  endfunction

  // Offers one request and returns at the edge where it is accepted. Valid
  // stays high afterwards so that back-to-back requests need no second
  // assignment in the same step; a gap or the caller lowers it.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    source_byte   <= b;
    end_of_source <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    verdict_q.insert(verdict_q.size(), scan_byte(b, last));
  endtask

  task automatic send_source(ref logic [7:0] text[$]);
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  // The limit is only rewritten once the block is drained and the input idle.
  task automatic write_limit(input logic [15:0] value);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    depth_limit = value;
  endtask

  // Small limits make flagging common; the extremes and any value show up too.
  function automatic logic [15:0] pick_limit();
    case ($urandom_range(9))
      0:       return 16'hFFFF;
      1:       return 16'h0000;
      2:       return 16'($urandom_range(65535));
      default: return 16'($urandom_range(6));
    endcase
  endfunction

  // Mostly characters the lexer reacts to, otherwise any byte.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(14))
      0:       return CH_LBRACE;
      1:       return CH_RBRACE;
      2:       return CH_LBRACK;
      3:       return CH_RBRACK;
      4:       return CH_DASH;
      5:       return CH_SQUOTE;
      6:       return CH_DQUOTE;
      7:       return CH_BSLASH;
      8:       return CH_NL;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Appends one byte at the end of a source under construction.
  function automatic void append_char(ref logic [7:0] text[$], input logic [7:0] b);
    text.insert(text.size(), b);
  endfunction

  // Builds one source from tokens: braces, strings with escapes, line and
  // block comments, lone and broken dash sequences, and raw noise bytes.
  task automatic make_source(ref logic [7:0] text[$]);
    int unsigned tok;
    logic [7:0]  q;
    logic [7:0]  c;
    text.delete();
    repeat ($urandom_range(1, 12)) begin
      tok = $urandom_range(11);
      case (tok)
        0, 1, 2: append_char(text, CH_LBRACE);
        3, 4:    append_char(text, CH_RBRACE);
        5, 6: begin
          q = (tok == 5) ? CH_SQUOTE : CH_DQUOTE;
          append_char(text, q);
          repeat ($urandom_range(5)) begin
            if ($urandom_range(3) == 0) begin
              append_char(text, CH_BSLASH);
              append_char(text, pick_char());
            end else begin
              c = pick_char();
              if (c != q && c != CH_BSLASH) append_char(text, c);
            end
          end
          // Now and then the string is left open to the end of the source.
          if ($urandom_range(9) != 0) append_char(text, q);
        end
        7: begin
          append_char(text, CH_DASH);
          append_char(text, CH_DASH);
          repeat ($urandom_range(4)) append_char(text, pick_char());
          append_char(text, CH_NL);
        end
        8: begin
          append_char(text, CH_DASH);
          append_char(text, CH_DASH);
          append_char(text, CH_LBRACK);
          append_char(text, CH_LBRACK);
          repeat ($urandom_range(5)) append_char(text, pick_char());
          append_char(text, CH_RBRACK);
          append_char(text, CH_RBRACK);
        end
        9: begin
          append_char(text, CH_DASH);
          append_char(text, pick_char());
        end
        10: begin
          append_char(text, CH_DASH);
          append_char(text, CH_DASH);
          append_char(text, CH_LBRACK);
          append_char(text, pick_char());
        end
        default: append_char(text, 8'($urandom_range(255)));
      endcase
    end
  endtask

  // Byte values 0x00 and 0xFF as plain code, under the limit loaded by reset.
  task automatic test_byte_extremes();
    send_byte(8'h00, 1'b0);
    send_byte(CH_LBRACE, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // With a limit of zero the first brace flags the source, and the flag
  // survives a closing brace.
  task automatic test_limit_floor();
    write_limit(16'h0000);
    send_text("{}");
  endtask

  // A close at depth zero, a pending dash before a brace, a quoted string
  // with an escaped quote, and a block comment; only the last brace flags.
  task automatic test_lexer_modes();
    write_limit(16'd1);
    send_text("}-{'\\'{'--[[{]]{");
  endtask

  // Dashes with one bracket become a line comment. Then a source that ends
  // on an escape inside a double-quoted string.
  task automatic test_comment_forms();
    send_text("--[{\n{{");
    send_text("\"\\");
  endtask

  // The limit is lowered in the middle of a source; the next brace is
  // compared with the new value. Then the top limit with a few braces.
  task automatic test_limit_change();
    write_limit(16'd5);
    send_byte(CH_LBRACE, 1'b0);
    send_byte(CH_LBRACE, 1'b0);
    write_limit(16'd1);
    send_byte(CH_LBRACE, 1'b1);
    write_limit(16'hFFFF);
    send_text("{{");
  endtask

  task automatic test_random_phase(input int unsigned gap_pct, input int unsigned hold_pct,
                                   input int unsigned n_bytes);
    logic [7:0]  text[$];
    int unsigned sent = 0;
    send_gap_pct = gap_pct;
    stall_pct    = hold_pct;
    write_limit(pick_limit());
    while (sent < n_bytes) begin
      if ($urandom_range(5) == 0) write_limit(pick_limit());
      make_source(text);
      send_source(text);
      sent += text.size();
    end
  endtask

  // The output is held off for a long stretch while requests keep coming,
  // so the block fills up and raises in_stall.
  task automatic test_backpressure();
    logic [7:0]  text[$];
    int unsigned sent = 0;
    send_gap_pct = 0;
    stall_pct    = 0;
    write_limit(pick_limit());
    stall_hold = 200;
    while (sent < 80) begin
      make_source(text);
      send_source(text);
      sent += text.size();
    end
  endtask

  // Result monitor: checks each accepted result against the oldest expected
  // verdict, then chooses the stall for the next cycle.
  initial begin : result_monitor
    bdg_result_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: result with no request pending: limit_exceeded %0b source_done %0b",
                   $time, limit_exceeded, source_done);
          mismatch_count++;
        end else begin
          want = verdict_q.pop_front();
          if (limit_exceeded !== want.limit_exceeded) begin
            $display("%0t: limit_exceeded expected %0b, actual %0b",
                     $time, want.limit_exceeded, limit_exceeded);
            mismatch_count++;
          end
          if (source_done !== want.source_done) begin
            $display("%0t: source_done expected %0b, actual %0b",
                     $time, want.source_done, source_done);
            mismatch_count++;
          end
        end
      end
      if (stall_hold != 0) begin
        out_stall  <= 1'b1;
        stall_hold -= 1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_byte_extremes();
    test_limit_floor();
    test_lexer_modes();
    test_comment_forms();
    test_limit_change();
    test_random_phase(0, 0, 300);
    test_random_phase(80, 0, 300);
    test_random_phase(0, 80, 300);
    test_random_phase(38, 38, 300);
    test_backpressure();

    // Drain, then keep the clock running so that any stray result shows.
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/bdg_pkg.sv
rtl/bdg_lexer.sv
rtl/bdg_out_buf.sv
rtl/brace_nesting_depth_guard_core.sv
verif/brace_nesting_depth_guard_core_tb.sv
